// ===== src/jac_pkg.sv =====
// Package for the J1939 address-claim block: codes, constants and the
// decision record passed from the frame decoder to the top level.
// No dependencies.
`default_nettype none

package jac_pkg;

    // Field widths.
    localparam int ADDR_W     = 8;
    localparam int NAME_W     = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NAME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREF_ADDR = 1'b1;

    // Input mode codes.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    // Result kind codes.
    localparam logic KIND_CLAIM = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // Protocol constants.
    localparam logic [ADDR_W-1:0] NULL_ADDR     = 8'd254;
    localparam logic [ADDR_W-1:0] GLOBAL_ADDR   = 8'hFF;
    localparam logic [ADDR_W-1:0] FIRST_ADDR    = 8'd1;
    localparam logic [ADDR_W-1:0] PREF_RESET    = 8'd128;
    localparam logic [7:0]        PF_REQUEST    = 8'hEA;
    localparam logic [7:0]        PF_CLAIM      = 8'hEE;
    localparam logic [7:0]        PF_BCAST_MIN  = 8'd240;
    localparam logic [LEN_W-1:0]  CLAIM_LEN     = 4'd8;

    // Number of results an item produces.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // Decoder verdict for one item.
    typedef struct packed {
        logic [1:0]        cnt;       // results to emit
        logic              upd;       // current address changes
        logic [ADDR_W-1:0] new_addr;  // address carried by the results
    } t_decision;

endpackage

`default_nettype wire

// ===== src/j1939_address_claim.sv =====
// Top level of the J1939 address-claim block: input register, address
// state, configuration registers and the output register.
// Depends on jac_pkg and jac_decide.
//
//  Channel   Handshake                  Beat carries
//  -------   -------------------------  ------------------------------------------
//  input     i_in_valid / o_in_stall    mode, PF, PS, SA, length, payload NAME
//  output    o_out_valid / i_out_stall  kind, claimed address, claimed NAME, last
//  config    i_cfg_valid / o_cfg_ready  register index, write data
//
// An item is registered on acceptance and decided from the input register;
// on retiring, the address state updates and its first result loads the
// output register. Items with no result or one result pass at one per cycle
// when not stalled; an item with a claim frame and a claim event holds the
// output register for two beats. Output stall backs up through the input
// register to o_in_stall. Synchronous active-low reset empties both registers
// and sets the address and preferred address to 128; config is always ready.
`default_nettype none

module j1939_address_claim (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_mode,
    input  wire logic [7:0]                     i_pf,
    input  wire logic [7:0]                     i_ps,
    input  wire logic [jac_pkg::ADDR_W-1:0]     i_src_addr,
    input  wire logic [jac_pkg::LEN_W-1:0]      i_data_length,
    input  wire logic [jac_pkg::NAME_W-1:0]     i_payload_name,
    // Output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_kind,
    output logic [jac_pkg::ADDR_W-1:0]          o_claimed_address,
    output logic [jac_pkg::NAME_W-1:0]          o_claimed_name,
    output logic                                o_last,
    // Configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [jac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [jac_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration and address state.
    logic [jac_pkg::NAME_W-1:0] r_own_name;
    logic [jac_pkg::ADDR_W-1:0] r_pref_addr;
    logic [jac_pkg::ADDR_W-1:0] r_cur_addr;

    // Input register.
    logic                       r_iv;
    logic                       r_mode;
    logic [7:0]                 r_pf;
    logic [7:0]                 r_ps;
    logic [jac_pkg::ADDR_W-1:0] r_sa;
    logic [jac_pkg::LEN_W-1:0]  r_len;
    logic [jac_pkg::NAME_W-1:0] r_pname;

    // Output register plus a pending claim event.
    logic                       r_ov;
    logic                       r_okind;
    logic                       r_olast;
    logic [jac_pkg::ADDR_W-1:0] r_oaddr;
    logic                       r_pend_ev;

    jac_pkg::t_decision dec;
    logic               in_acc;
    logic               out_pop;
    logic               out_free;
    logic               consume;

    jac_decide u_decide (
        .i_mode           (r_mode),
        .i_pf             (r_pf),
        .i_ps             (r_ps),
        .i_src_addr       (r_sa),
        .i_data_length    (r_len),
        .i_payload_name   (r_pname),
        .i_cur_addr       (r_cur_addr),
        .i_pref_addr      (r_pref_addr),
        .i_own_name       (r_own_name),
        .o_dec            (dec)
    );

    // Flow control: the registered item retires when its results fit.
    assign out_pop    = r_ov && !i_out_stall;
    assign out_free   = !r_ov || (out_pop && !r_pend_ev);
    assign consume    = r_iv && ((dec.cnt == jac_pkg::CNT_NONE) || out_free);
    assign o_in_stall = r_iv && !consume;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers and address state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_name  <= '0;
            r_pref_addr <= jac_pkg::PREF_RESET;
            r_cur_addr  <= jac_pkg::PREF_RESET;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    jac_pkg::CFG_OWN_NAME:  r_own_name  <= i_cfg_data;
                    jac_pkg::CFG_PREF_ADDR: r_pref_addr <= i_cfg_data[jac_pkg::ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (consume && dec.upd) begin
                r_cur_addr <= dec.new_addr;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (in_acc) begin
            r_iv <= 1'b1;
        end else if (consume) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_pf    <= i_pf;
            r_ps    <= i_ps;
            r_sa    <= i_src_addr;
            r_len   <= i_data_length;
            r_pname <= i_payload_name;
        end
    end

    // Output register: first result on load, claim event on the next pop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov      <= 1'b0;
            r_pend_ev <= 1'b0;
        end else if (consume && (dec.cnt != jac_pkg::CNT_NONE)) begin
            r_ov      <= 1'b1;
            r_pend_ev <= (dec.cnt == jac_pkg::CNT_TWO);
        end else if (out_pop) begin
            r_ov      <= r_pend_ev;
            r_pend_ev <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && (dec.cnt != jac_pkg::CNT_NONE)) begin
            r_okind <= jac_pkg::KIND_CLAIM;
            r_olast <= (dec.cnt == jac_pkg::CNT_ONE);
            r_oaddr <= dec.new_addr;
        end else if (out_pop && r_pend_ev) begin
            r_okind <= jac_pkg::KIND_EVENT;
            r_olast <= 1'b1;
        end
    end

    // The user must change the NAME only while the block is idle; the block does not enforce this. It is read directly.
    assign o_out_valid       = r_ov;
    assign o_kind            = r_okind;
    assign o_last            = r_olast;
    assign o_claimed_address = r_oaddr;
    assign o_claimed_name    = r_own_name;

endmodule

`default_nettype wire

// ===== src/jac_decide.sv =====
// Frame decoder for the J1939 address-claim block: decides how many
// results one item produces and what the node's address becomes.
// Depends on jac_pkg.
`default_nettype none

module jac_decide (
    input  wire logic                       i_mode,
    input  wire logic [7:0]                 i_pf,
    input  wire logic [7:0]                 i_ps,
    input  wire logic [jac_pkg::ADDR_W-1:0] i_src_addr,
    input  wire logic [jac_pkg::LEN_W-1:0]  i_data_length,
    input  wire logic [jac_pkg::NAME_W-1:0] i_payload_name,
    input  wire logic [jac_pkg::ADDR_W-1:0] i_cur_addr,
    input  wire logic [jac_pkg::ADDR_W-1:0] i_pref_addr,
    input  wire logic [jac_pkg::NAME_W-1:0] i_own_name,
    output jac_pkg::t_decision              o_dec
);

    logic                       bcast;
    logic                       for_us;
    logic [jac_pkg::ADDR_W-1:0] step_addr;
    logic [jac_pkg::ADDR_W-1:0] wrap_addr;

    // Destination filter: broadcast PGNs and global frames pass, others
    // only when addressed to our current address.
    assign bcast  = (i_pf >= jac_pkg::PF_BCAST_MIN) ||
                    (i_ps == jac_pkg::GLOBAL_ADDR);
    assign for_us = bcast || (i_ps == i_cur_addr);

    // Next address to try after a lost contest; gives up at the preferred one.
    assign step_addr = i_cur_addr + jac_pkg::ADDR_W'(1);
    always_comb begin
        wrap_addr = step_addr;
        if (step_addr >= jac_pkg::NULL_ADDR) begin
            wrap_addr = jac_pkg::FIRST_ADDR;
        end
        if (wrap_addr == i_pref_addr) begin
            wrap_addr = jac_pkg::NULL_ADDR;
        end
    end

    // Verdict.
    always_comb begin
        o_dec.cnt      = jac_pkg::CNT_NONE;
        o_dec.upd      = 1'b0;
        o_dec.new_addr = i_cur_addr;
        if (i_mode == jac_pkg::MODE_START) begin
            o_dec.cnt = jac_pkg::CNT_TWO;
        end else if (for_us) begin
            if ((i_pf == jac_pkg::PF_CLAIM) && (i_src_addr == i_cur_addr)) begin
                // Contending claim: ignored while null or when not a full NAME.
                if ((i_cur_addr != jac_pkg::NULL_ADDR) &&
                    (i_data_length == jac_pkg::CLAIM_LEN)) begin
                    if (i_own_name <= i_payload_name) begin
                        o_dec.cnt = jac_pkg::CNT_ONE;
                    end else begin
                        o_dec.cnt      = jac_pkg::CNT_TWO;
                        o_dec.upd      = 1'b1;
                        o_dec.new_addr = i_own_name[jac_pkg::NAME_W-1] ? wrap_addr
                                                                       : jac_pkg::NULL_ADDR;
                    end
                end
            end else if ((i_pf == jac_pkg::PF_REQUEST) &&
                         ((i_ps == jac_pkg::GLOBAL_ADDR) ||
                          (i_ps == i_cur_addr))) begin
                o_dec.cnt = jac_pkg::CNT_ONE;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/jac_checker.sv =====
// Port-level checker for the J1939 address-claim block, with its bind.
// Depends on jac_pkg and on the ports of j1939_address_claim.
`default_nettype none

module jac_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic                       o_kind,
    input wire logic                       o_last,
    input wire logic [jac_pkg::ADDR_W-1:0] o_claimed_address
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled beat holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) &&
            $stable(o_claimed_address) && $stable(o_last))
        else $error("stalled output beat changed");

    // A claim event always closes the results of its item.
    a_event_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == jac_pkg::KIND_EVENT) |-> o_last)
        else $error("claim event not marked last");

    // A claim frame that is not last is followed at once by its event,
    // at the same address.
    a_event_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && (o_kind == jac_pkg::KIND_CLAIM) && !o_last
        |=> o_out_valid && (o_kind == jac_pkg::KIND_EVENT) && $stable(o_claimed_address))
        else $error("claim event missing after claim frame");

    // The global address is never claimed.
    a_no_global: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_claimed_address != jac_pkg::GLOBAL_ADDR))
        else $error("global address claimed");

endmodule

bind j1939_address_claim jac_checker u_jac_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_kind            (o_kind),
    .o_last            (o_last),
    .o_claimed_address (o_claimed_address)
);

`default_nettype wire
